@@ rtl/png_scanline_unfilter_assert.svh @@
// Assertion macros for the checker module of the scanline unfilter.
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// Checked at every rising edge of clk, switched off while arst_n is low.
`define PSU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge of clk, also during reset.
`define PSU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/psu_pkg.sv @@
`default_nettype none

package psu_pkg;

	localparam int MAX_ROW_BYTES_DEF = 4096;
	localparam int MAX_BPP_DEF       = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int BPP_W      = 4;
	localparam int ROWB_W     = 13;
	localparam int ROWS_W     = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_BPP       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMG_ROWS  = 2'd2;

	// Filter type as it appears in the filter byte; other codes act as None.
	typedef enum logic [7:0] {
		FLT_NONE  = 8'd0,
		FLT_SUB   = 8'd1,
		FLT_UP    = 8'd2,
		FLT_AVG   = 8'd3,
		FLT_PAETH = 8'd4
	} filt_t;

	typedef struct packed {
		logic [7:0] data;
		filt_t      filter;
		logic       first_row;
		logic       has_left;
		logic       last_col;
		logic       last_row;
	} item_t;

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic signed [9:0] da;
		logic signed [9:0] db;
		logic signed [9:0] dsum;
		logic [9:0] pa;
		logic [9:0] pb;
		logic [9:0] pc;
		logic [7:0] res;
		da   = $signed({2'b00, a}) - $signed({2'b00, c});
		db   = $signed({2'b00, b}) - $signed({2'b00, c});
		dsum = da + db;
		// Distances from p = a + b - c to a, b and c.
		pa = db[9] ? 10'(-db) : 10'(db);
		pb = da[9] ? 10'(-da) : 10'(da);
		pc = dsum[9] ? 10'(-dsum) : 10'(dsum);
		if (pa <= pb && pa <= pc) begin
			res = a;
		end else if (pb <= pc) begin
			res = b;
		end else begin
			res = c;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

@@ rtl/png_scanline_unfilter.sv @@
// PNG scanline reconstruction for filter types None, Sub, Up, Average and Paeth.
// The slave stream carries the inflated image one byte per word: per scanline a
// filter-type byte, then row_bytes filtered bytes; tuser marks the first byte
// of an image. The master stream returns one word per data byte: tdata is the
// reconstructed byte, tlast marks the last byte of a scanline and tuser the
// last byte of the image. Filter bytes produce no output word.
// Configuration (bytes_per_pixel, row_bytes, image_rows) is written through
// cfg_wen/cfg_index/cfg_wdata; the user must do so only while no word is in
// flight, which the block does not enforce. Throughput is one byte per cycle
// while the master side accepts, sustained across row boundaries; the loop that
// sets it is the predictor from the previous output byte. The input byte and
// the line-store read of the byte above are registered, then the output word.
// The line store is one single-port-write, single-port-read RAM of
// MAX_ROW_BYTES bytes that the current row overwrites in place.
// Reset clears the counters and histories and returns to the first filter byte
// of the first row; the line store is not cleared, since the first row never
// uses it. When the master side stalls, the output word holds and one more
// word waits in the read stage; s_tready drops only while both are full.
`default_nettype none

module png_scanline_unfilter #(
	parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF,
	parameter int MAX_BPP       = psu_pkg::MAX_BPP_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wen,
	input  wire logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [psu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [7:0]                      s_tdata,  // filtered_byte
	input  wire logic                            s_tuser,  // image_start
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [7:0]                      m_tdata,  // recon_byte
	output logic                                 m_tlast,  // row_end
	output logic                                 m_tuser   // image_end
);

	localparam int IDXW = $clog2(MAX_ROW_BYTES);
	localparam int HW   = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

	logic             adv;
	logic             rd_en;
	logic [IDXW-1:0]  rd_addr;
	logic [7:0]       rd_data;
	logic             wr_en;
	logic [IDXW-1:0]  wr_addr;
	logic [7:0]       wr_data;
	logic             s1_valid;
	psu_pkg::item_t   item_s1;
	logic [IDXW-1:0]  idx_s1;
	logic [HW-1:0]    tap_sel;

	psu_ctrl #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES),
		.MAX_BPP      (MAX_BPP)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.adv      (adv),
		.s_tready (s_tready),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.s1_valid (s1_valid),
		.item_s1  (item_s1),
		.idx_s1   (idx_s1),
		.tap_sel  (tap_sel)
	);

	psu_ram #(
		.WIDTH(8),
		.DEPTH(MAX_ROW_BYTES)
	) u_line (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	psu_recon #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES),
		.MAX_BPP      (MAX_BPP)
	) u_recon (
		.clk     (clk),
		.arst_n  (arst_n),
		.s1_valid(s1_valid),
		.item_s1 (item_s1),
		.idx_s1  (idx_s1),
		.tap_sel (tap_sel),
		.rd_data (rd_data),
		.m_tready(m_tready),
		.adv     (adv),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule

`default_nettype wire

@@ rtl/psu_ram.sv @@
`default_nettype none

module psu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/psu_ctrl.sv @@
`default_nettype none

module psu_ctrl #(
	parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF,
	parameter int MAX_BPP       = psu_pkg::MAX_BPP_DEF,
	localparam int IDXW = $clog2(MAX_ROW_BYTES),
	localparam int HW   = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wen,
	input  wire logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [psu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                            s_tvalid,
	input  wire logic [7:0]                      s_tdata,
	input  wire logic                            s_tuser,
	input  wire logic                            adv,
	output logic                                 s_tready,
	output logic                                 rd_en,
	output logic      [IDXW-1:0]                 rd_addr,
	output logic                                 s1_valid,
	output psu_pkg::item_t                       item_s1,
	output logic      [IDXW-1:0]                 idx_s1,
	output logic      [HW-1:0]                   tap_sel
);

	localparam int COLW = $clog2(MAX_ROW_BYTES + 1);
	localparam int RBW  = (COLW > psu_pkg::ROWB_W) ? COLW : psu_pkg::ROWB_W;

	logic [psu_pkg::BPP_W-1:0]  bpp_q;
	logic [psu_pkg::ROWB_W-1:0] row_bytes_q;
	logic [psu_pkg::ROWS_W-1:0] image_rows_q;

	logic [COLW-1:0]            col_q;
	logic [psu_pkg::ROWS_W-1:0] row_q;
	logic                       first_row_q;
	psu_pkg::filt_t             filter_q;

	logic [psu_pkg::BPP_W-1:0]  bpp_eff;
	logic [RBW-1:0]             rb_ext;
	logic [RBW-1:0]             rb_eff;
	logic [psu_pkg::ROWS_W-1:0] rows_eff;
	logic                       accept;
	logic [COLW-1:0]            col_cur;
	logic [psu_pkg::ROWS_W-1:0] row_cur;
	logic                       fr_cur;
	logic                       is_filter;
	logic [COLW-1:0]            idx_full;
	logic [IDXW-1:0]            idx;
	logic                       last_col;
	logic                       last_row;
	logic                       has_left;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q        <= psu_pkg::BPP_W'(1);
			row_bytes_q  <= psu_pkg::ROWB_W'(1);
			image_rows_q <= psu_pkg::ROWS_W'(1);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				psu_pkg::CFG_BPP:       bpp_q        <= cfg_wdata[psu_pkg::BPP_W-1:0];
				psu_pkg::CFG_ROW_BYTES: row_bytes_q  <= cfg_wdata[psu_pkg::ROWB_W-1:0];
				psu_pkg::CFG_IMG_ROWS:  image_rows_q <= cfg_wdata[psu_pkg::ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (bpp_q == '0) begin
			bpp_eff = psu_pkg::BPP_W'(1);
		end else if (bpp_q > psu_pkg::BPP_W'(MAX_BPP)) begin
			bpp_eff = psu_pkg::BPP_W'(MAX_BPP);
		end else begin
			bpp_eff = bpp_q;
		end
		rb_ext = RBW'(row_bytes_q);
		if (rb_ext == '0) begin
			rb_eff = RBW'(1);
		end else if (rb_ext > RBW'(MAX_ROW_BYTES)) begin
			rb_eff = RBW'(MAX_ROW_BYTES);
		end else begin
			rb_eff = rb_ext;
		end
		rows_eff = (image_rows_q == '0) ? psu_pkg::ROWS_W'(1) : image_rows_q;
	end

	assign tap_sel  = HW'(bpp_eff - psu_pkg::BPP_W'(1));
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	// An image start forces the counters back to the first filter byte.
	assign col_cur   = s_tuser ? '0 : col_q;
	assign row_cur   = s_tuser ? '0 : row_q;
	assign fr_cur    = s_tuser ? 1'b1 : first_row_q;
	assign is_filter = (col_cur == '0);
	assign idx_full  = col_cur - COLW'(1);
	assign idx       = idx_full[IDXW-1:0];
	assign last_col  = RBW'(idx) >= (rb_eff - RBW'(1));
	assign last_row  = last_col && (row_cur >= (rows_eff - psu_pkg::ROWS_W'(1)));
	assign has_left  = idx >= IDXW'(bpp_eff);

	assign rd_en   = accept && !is_filter;
	assign rd_addr = idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			first_row_q <= 1'b1;
			filter_q    <= psu_pkg::FLT_NONE;
		end else if (accept) begin
			if (is_filter) begin
				filter_q    <= psu_pkg::filt_t'(s_tdata);
				col_q       <= COLW'(1);
				row_q       <= row_cur;
				first_row_q <= fr_cur;
			end else if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q       <= '0;
					first_row_q <= 1'b1;
				end else begin
					row_q       <= row_cur + psu_pkg::ROWS_W'(1);
					first_row_q <= 1'b0;
				end
			end else begin
				col_q       <= col_cur + COLW'(1);
				row_q       <= row_cur;
				first_row_q <= fr_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (adv) begin
			s1_valid <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			item_s1.data      <= s_tdata;
			item_s1.filter    <= filter_q;
			item_s1.first_row <= fr_cur;
			item_s1.has_left  <= has_left;
			item_s1.last_col  <= last_col;
			item_s1.last_row  <= last_row;
			idx_s1            <= idx;
		end
	end

endmodule

`default_nettype wire

@@ rtl/psu_recon.sv @@
`default_nettype none

module psu_recon #(
	parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF,
	parameter int MAX_BPP       = psu_pkg::MAX_BPP_DEF,
	localparam int IDXW = $clog2(MAX_ROW_BYTES),
	localparam int HW   = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s1_valid,
	input  wire psu_pkg::item_t    item_s1,
	input  wire logic [IDXW-1:0]   idx_s1,
	input  wire logic [HW-1:0]     tap_sel,
	input  wire logic [7:0]        rd_data,
	input  wire logic              m_tready,
	output logic                   adv,
	output logic                   wr_en,
	output logic      [IDXW-1:0]   wr_addr,
	output logic      [7:0]        wr_data,
	output logic                   m_tvalid,
	output logic      [7:0]        m_tdata,
	output logic                   m_tlast,
	output logic                   m_tuser
);

	// Last reconstructed bytes and last above bytes of the row, newest first.
	logic [7:0] left_q [MAX_BPP];
	logic [7:0] upleft_q [MAX_BPP];

	logic       out_free;
	logic [7:0] a;
	logic [7:0] b;
	logic [7:0] c;
	logic [8:0] avg_sum;
	logic [7:0] pred;
	logic [7:0] recon;

	assign out_free = !m_tvalid || m_tready;
	assign adv      = !s1_valid || out_free;

	// Before the first full pixel of a row the left-side bytes are zero, so the
	// histories never need clearing between rows.
	assign b = item_s1.first_row ? 8'd0 : rd_data;
	assign a = item_s1.has_left ? left_q[tap_sel] : 8'd0;
	assign c = (item_s1.has_left && !item_s1.first_row) ? upleft_q[tap_sel] : 8'd0;
	assign avg_sum = {1'b0, a} + {1'b0, b};

	always_comb begin
		case (item_s1.filter)
			psu_pkg::FLT_SUB:   pred = a;
			psu_pkg::FLT_UP:    pred = b;
			psu_pkg::FLT_AVG:   pred = avg_sum[8:1];
			psu_pkg::FLT_PAETH: pred = psu_pkg::paeth(a, b, c);
			default:            pred = 8'd0;
		endcase
	end

	assign recon   = item_s1.data + pred;
	assign wr_en   = s1_valid && adv;
	assign wr_addr = idx_s1;
	assign wr_data = recon;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_BPP; k++) begin
				left_q[k]   <= 8'd0;
				upleft_q[k] <= 8'd0;
			end
		end else if (wr_en) begin
			for (int k = MAX_BPP - 1; k > 0; k--) begin
				left_q[k]   <= left_q[k-1];
				upleft_q[k] <= upleft_q[k-1];
			end
			left_q[0]   <= recon;
			upleft_q[0] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			m_tdata <= recon;
			m_tlast <= item_s1.last_col;
			m_tuser <= item_s1.last_row;
		end
	end

endmodule

`default_nettype wire

@@ rtl/psu_checker.sv @@
`default_nettype none
`include "png_scanline_unfilter_assert.svh"

module psu_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast,
	input wire logic       m_tuser
);

	// A stalled output word must stay in place.
	`PSU_ASSERT(a_out_hold,
		m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tlast, m_tuser}),
		"output word changed while stalled")

	// The last byte of an image is always the last byte of a scanline.
	`PSU_ASSERT(a_img_end_row_end, m_tvalid && m_tuser |-> m_tlast, "image end without row end")

	// A receiver that takes words never throttles the input side.
	`PSU_ASSERT(a_no_false_stall, m_tready |-> s_tready, "input stalled while output drains")

	// Nothing comes out in the first cycle after reset.
	`PSU_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !m_tvalid, "output word right after reset")

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (.*);

`default_nettype wire

@@ tb/sv/png_unfilter_recon_check.sv @@
`timescale 1ns / 1ps

module png_unfilter_recon_check (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wen,
	input  wire logic [psu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [psu_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  wire logic                                s_tvalid,
	input  wire logic                                s_tready,
	input  wire logic [7:0]                          s_tdata,  // filtered_byte
	input  wire logic                                s_tuser,  // image_start
	input  wire logic                                m_tvalid,
	input  wire logic                                m_tready,
	input  wire logic [7:0]                          m_tdata,  // recon_byte
	input  wire logic                                m_tlast,  // row_end
	input  wire logic                                m_tuser,  // image_end
	output int                                       mismatches,
	output int                                       pending_words
);
	import psu_pkg::*;

	typedef struct packed {
		logic [7:0] recon;
		logic       row_end;
		logic       image_end;
	} recon_word_t;

	recon_word_t expected_recon[$];
	recon_word_t want;
	recon_word_t got;

	// Shadow copies of the registers, as written.
	logic [BPP_W-1:0]  reg_bpp;
	logic [ROWB_W-1:0] reg_row_bytes;
	logic [ROWS_W-1:0] reg_rows;

	logic [7:0]  prev_row [0:MAX_ROW_BYTES_DEF-1];
	logic [7:0]  left_hist [0:MAX_BPP_DEF-1];
	logic [7:0]  upleft_hist [0:MAX_BPP_DEF-1];
	logic [7:0]  cur_filter;
	logic [12:0] column_pos;
	logic [15:0] row_index;
	logic        on_first_row;

	int         fail_tally;
	int         bpp_eff;
	int         rb_eff;
	int         rows_eff;
	int         idx;
	int         k;
	logic [7:0] left_byte;
	logic [7:0] above_byte;
	logic [7:0] upleft_byte;
	logic [7:0] guess;
	logic [8:0] pair_sum;
	logic       row_done;
	logic       image_done;

	function automatic int gap(input int x, input int y);
		return x > y ? x - y : y - x;
	endfunction

	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		int est;
		int dist_a;
		int dist_b;
		int dist_c;
		est    = int'(a) + int'(b) - int'(c);
		dist_a = gap(est, int'(a));
		dist_b = gap(est, int'(b));
		dist_c = gap(est, int'(c));
		if (dist_a <= dist_b && dist_a <= dist_c) begin
			return a;
		end else if (dist_b <= dist_c) begin
			return b;
		end
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_recon.delete();
			reg_bpp       = 1;
			reg_row_bytes = 1;
			reg_rows      = 1;
			for (k = 0; k < MAX_ROW_BYTES_DEF; k++) begin
				prev_row[k] = 8'h00;
			end
			for (k = 0; k < MAX_BPP_DEF; k++) begin
				left_hist[k]   = 8'h00;
				upleft_hist[k] = 8'h00;
			end
			cur_filter    = 8'h00;
			column_pos    = 0;
			row_index     = 0;
			on_first_row  = 1'b1;
			fail_tally    = 0;
			mismatches    <= 0;
			pending_words <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{recon: m_tdata, row_end: m_tlast, image_end: m_tuser};
				if (expected_recon.size() == 0) begin
					$display("%0t: unexpected word: recon %h row_end %b image_end %b",
						$time, got.recon, got.row_end, got.image_end);
					fail_tally++;
				end else begin
					want = expected_recon.pop_front();
					if (got.recon !== want.recon || got.row_end !== want.row_end ||
						got.image_end !== want.image_end) begin
						$display("%0t: expected recon %h row_end %b image_end %b, got %h %b %b",
							$time, want.recon, want.row_end, want.image_end,
							got.recon, got.row_end, got.image_end);
						fail_tally++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				// Out-of-range register values saturate into the legal range.
				bpp_eff  = (reg_bpp == 0) ? 1 : (reg_bpp > MAX_BPP_DEF) ? MAX_BPP_DEF :
					int'(reg_bpp);
				rb_eff   = (reg_row_bytes == 0) ? 1 :
					(reg_row_bytes > MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF :
					int'(reg_row_bytes);
				rows_eff = (reg_rows == 0) ? 1 : int'(reg_rows);

				if (s_tuser) begin
					row_index    = 0;
					on_first_row = 1'b1;
					column_pos   = 0;
				end
				if (column_pos == 0) begin
					cur_filter = s_tdata;
					for (k = 0; k < MAX_BPP_DEF; k++) begin
						left_hist[k]   = 8'h00;
						upleft_hist[k] = 8'h00;
					end
					column_pos = 1;
				end else begin
					idx         = int'(column_pos) - 1;
					above_byte  = on_first_row ? 8'h00 : prev_row[idx];
					left_byte   = (idx >= bpp_eff) ? left_hist[bpp_eff-1] : 8'h00;
					upleft_byte = (!on_first_row && idx >= bpp_eff) ?
						upleft_hist[bpp_eff-1] : 8'h00;
					pair_sum    = {1'b0, left_byte} + {1'b0, above_byte};
					case (cur_filter)
						FLT_SUB:   guess = left_byte;
						FLT_UP:    guess = above_byte;
						FLT_AVG:   guess = pair_sum[8:1];
						FLT_PAETH: guess = paeth_pick(left_byte, above_byte, upleft_byte);
						default:   guess = 8'h00;
					endcase
					want.recon = s_tdata + guess;

					for (k = MAX_BPP_DEF - 1; k > 0; k--) begin
						left_hist[k]   = left_hist[k-1];
						upleft_hist[k] = upleft_hist[k-1];
					end
					left_hist[0]   = want.recon;
					upleft_hist[0] = above_byte;
					prev_row[idx]  = want.recon;

					row_done   = (idx >= rb_eff - 1);
					image_done = 1'b0;
					if (row_done) begin
						column_pos = 0;
						if (int'(row_index) >= rows_eff - 1) begin
							image_done   = 1'b1;
							row_index    = 0;
							on_first_row = 1'b1;
						end else begin
							row_index    = row_index + 1'b1;
							on_first_row = 1'b0;
						end
					end else begin
						column_pos = column_pos + 1'b1;
					end
					want.row_end   = row_done;
					want.image_end = image_done;
					expected_recon.push_back(want);
				end
			end

			// A write in the same cycle as an input word only affects later words.
			if (cfg_wen) begin
				case (cfg_index)
					CFG_BPP:       reg_bpp = cfg_wdata[BPP_W-1:0];
					CFG_ROW_BYTES: reg_row_bytes = cfg_wdata[ROWB_W-1:0];
					CFG_IMG_ROWS:  reg_rows = cfg_wdata[ROWS_W-1:0];
					default:       ;
				endcase
			end

			pending_words <= expected_recon.size();
			mismatches    <= fail_tally;
		end
	end

endmodule

@@ tb/sv/tb_png_scanline_unfilter.sv @@
`timescale 1ns / 1ps

module tb_png_scanline_unfilter;
	import psu_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_WORDS = 1350;
	localparam int HOLD_EVERY   = 500;
	localparam int HOLD_CYCLES  = 64;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	int mismatches;
	int pending_words;
	int sent_words;
	int recv_words;
	int setting_count;
	int cycles_run;
	int eff_rb;
	int eff_rows;
	bit no_idle;

	png_scanline_unfilter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	png_unfilter_recon_check recon_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.m_tuser       (m_tuser),
		.mismatches    (mismatches),
		.pending_words (pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles_run = 0;
		while (cycles_run < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles_run++;
		end
		$display("png_scanline_unfilter: mismatch");
		$finish;
	end

	// Receiver: random stalls, and every few hundred words a long hold-off so
	// that the block fills up and pushes back on its input.
	initial begin
		int stall;
		m_tready   = 1'b0;
		recv_words = 0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 7);
			if (recv_words % HOLD_EVERY == HOLD_EVERY - 1) begin
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			recv_words++;
		end
	end

	// Leaves s_tvalid high after acceptance; the next call or a drain replaces it.
	task automatic send_word(input logic [7:0] d, input logic st);
		int idle;
		idle = no_idle ? 0 : $urandom_range(0, 7);
		if (idle > 0) begin
			s_tvalid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= st;
		do @(posedge clk); while (!s_tready);
		sent_words++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0) @(posedge clk);
		// A trailing filter byte gives no word, so allow the pipeline to settle.
		repeat (4) @(posedge clk);
	endtask

	// Bits above the register width carry random values.
	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int value,
		input logic [CFG_DATA_W-1:0] field_mask);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= (CFG_DATA_W'($urandom) & ~field_mask) |
			(CFG_DATA_W'(value) & field_mask);
		@(posedge clk);
	endtask

	task automatic configure(input int bpp, input int rb, input int rows);
		write_cfg(CFG_BPP, bpp, 16'h000F);
		write_cfg(CFG_ROW_BYTES, rb, 16'h1FFF);
		write_cfg(CFG_IMG_ROWS, rows, 16'hFFFF);
		cfg_wen <= 1'b0;
		eff_rb   = (rb == 0) ? 1 : (rb > MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF : rb;
		eff_rows = (rows == 0) ? 1 : rows;
		setting_count++;
	endtask

	task automatic send_row(input logic [7:0] filter, input logic st, input int ndata);
		int pick;
		logic [7:0] d;
		send_word(filter, st);
		for (int i = 0; i < ndata; i++) begin
			pick = $urandom_range(0, 7);
			d = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
			send_word(d, 1'b0);
			// Now and then the sender waits mid-row until the block has emptied.
			if ($urandom_range(0, 299) == 0) begin
				drain_results();
			end
		end
	endtask

	initial begin
		int base_words;
		int bpp;
		int rb;
		int rows;
		int n_images;
		int nrows;
		int ndata;
		int top_rows;
		logic [7:0] filter;
		bit restart;
		bit cut;

		arst_n        = 1'b0;
		cfg_wen       = 1'b0;
		cfg_index     = CFG_BPP;
		cfg_wdata     = '0;
		s_tvalid      = 1'b0;
		s_tdata       = 8'h00;
		s_tuser       = 1'b0;
		no_idle       = 1'b0;
		sent_words    = 0;
		setting_count = 0;
		eff_rb        = 1;
		eff_rows      = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one-byte rows, one-row images; the second image follows
		// the first without an image-start mark.
		send_word(FLT_SUB, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(FLT_PAETH, 1'b0);
		send_word(8'h00, 1'b0);
		drain_results();

		// Paeth, Up, Average and None across a four-row image, byte extremes included.
		configure(2, 3, 4);
		write_cfg(CFG_SPARE, 16'hFFFF, 16'hFFFF);
		cfg_wen <= 1'b0;
		send_word(FLT_PAETH, 1'b1);
		send_word(8'hFF, 1'b0);
		send_word(8'h01, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(FLT_UP, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h7F, 1'b0);
		send_word(FLT_AVG, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(FLT_NONE, 1'b0);
		send_word(8'h10, 1'b0);
		send_word(8'h20, 1'b0);
		send_word(8'h30, 1'b0);
		// A new image, then another that starts mid-row with an unknown filter code.
		send_word(FLT_SUB, 1'b1);
		send_word(8'hAA, 1'b0);
		send_word(8'hFF, 1'b1);
		send_word(8'h55, 1'b0);
		send_word(8'hC3, 1'b0);
		send_word(8'h3C, 1'b0);
		drain_results();

		// Widest pixels, written out of range, across a two-row image.
		configure(15, 64, 2);
		send_row(FLT_SUB, 1'b1, eff_rb);
		send_row(FLT_PAETH, 1'b0, eff_rb);
		drain_results();

		// Random settings; each phase opens a new image and ends on a row boundary,
		// so a longer row never reads bytes that the previous row did not write.
		base_words = sent_words;
		while (sent_words - base_words < RANDOM_WORDS) begin
			drain_results();
			no_idle = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0:       bpp = 0;
				1:       bpp = $urandom_range(9, 15);
				2:       bpp = 1;
				3:       bpp = 8;
				default: bpp = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 9))
				0:       rb = 0;
				1, 2:    rb = $urandom_range(17, 80);
				default: rb = $urandom_range(1, 16);
			endcase
			case ($urandom_range(0, 7))
				0:       rows = 0;
				1:       rows = 65535;
				default: rows = $urandom_range(1, 5);
			endcase
			configure(bpp, rb, rows);

			n_images = $urandom_range(1, 3);
			restart  = 1'b1;
			for (int img = 0; img < n_images; img++) begin
				top_rows = (eff_rows > 6) ? 6 : eff_rows;
				nrows    = eff_rows;
				if (eff_rows > 6 || $urandom_range(0, 5) == 0) begin
					nrows = $urandom_range(1, top_rows);
				end
				cut = 1'b0;
				for (int r = 0; r < nrows && !cut; r++) begin
					filter = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 255)) :
						8'($urandom_range(0, 4));
					ndata = eff_rb;
					if (img != n_images - 1 && $urandom_range(0, 39) == 0) begin
						ndata = $urandom_range(0, eff_rb - 1);
						cut   = 1'b1;
					end
					send_row(filter, (r == 0) ? restart : 1'b0, ndata);
				end
				restart = (cut || nrows < eff_rows) ? 1'b1 : 1'($urandom_range(0, 1));
			end
		end
		drain_results();

		$display("Covered %0d input words and %0d checked output words over %0d settings,",
			sent_words, recv_words, setting_count);
		$display("with all filter codes, saturated registers, long rows and image restarts.");
		if (mismatches == 0) begin
			$display("png_scanline_unfilter: match");
		end else begin
			$display("png_scanline_unfilter: mismatch");
		end
		$finish;
	end

endmodule
